>>> hw/rtl/sukt_pkg.sv
// Shared constants and types for the sorted unique key table.
package sukt_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int OUT_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_DUMP   = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

endpackage

>>> hw/rtl/sorted_unique_key_table_core.sv
// Sorted unique key table: sequencer, key memory and output register.
// Search, delete and insert first scan the entries below the key (S_SCAN, S_CMP); then
// insert shifts each entry above it up (S_INS_RD, S_INS_WR) and delete shifts each
// entry after it down (S_DEL_RD, S_DEL_WR). Dump emits the stored keys in order.
// One item at a time: s_tready is high only in S_IDLE. The key memory has a registered read.
// Reset clears the key count, the state and m_tvalid; the key memory is not cleared.
module sorted_unique_key_table_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sukt_pkg::KEY_W-1:0]        s_tdata,  // [31:0] key
  input  logic [sukt_pkg::KIND_W-1:0]       s_tuser,  // [1:0] kind
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sukt_pkg::OUT_DATA_W-1:0]   m_tdata,  // [31:0] value, [38:32] count
  output logic [sukt_pkg::STATUS_W-1:0]     m_tuser,  // [2:0] status
  output logic                              m_tlast   // last result of the item
);
  import sukt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_EMIT
  } state_t;

  state_t               state;
  kind_t                op;
  logic [KEY_W-1:0]     key_reg;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     pos;
  logic                 match;
  status_t              res_status;
  logic [VALUE_W-1:0]   res_value;

  // Key memory and its port controls
  logic [KEY_W-1:0]     mem [CAPACITY];
  logic [KEY_W-1:0]     rd_data;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 we;
  logic [ADDR_W-1:0]    wr_addr;
  logic [KEY_W-1:0]     wr_data;

  logic                 out_free;
  logic                 emit_now;
  logic [CNT_W-1:0]     idx_inc;
  logic [CNT_W-1:0]     idx_dec;
  logic                 dump_last;

  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign emit_now  = out_free && (state == S_EMIT || state == S_DUMP_OUT);
  assign idx_inc   = idx + CNT_W'(1);
  assign idx_dec   = idx - CNT_W'(1);
  assign dump_last = (idx_inc == cnt);

  // Drive memory port from the sequencer state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[ADDR_W-1:0];
    we      = 1'b0;
    wr_addr = idx[ADDR_W-1:0];
    wr_data = rd_data;
    unique case (state)
      S_SCAN: begin
        rd_en = (idx != cnt);
      end
      S_INS_RD: begin
        rd_en   = (idx != pos);
        rd_addr = idx_dec[ADDR_W-1:0];
      end
      S_INS_WR: begin
        we = 1'b1;
      end
      S_INS_PUT: begin
        we      = 1'b1;
        wr_addr = pos[ADDR_W-1:0];
        wr_data = key_reg;
      end
      S_DEL_RD: begin
        rd_en   = (idx_inc != cnt);
        rd_addr = idx_inc[ADDR_W-1:0];
      end
      S_DEL_WR: begin
        we = 1'b1;
      end
      S_DUMP_RD: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Hold keys; registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Load or release the output register
      if (emit_now) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op      <= kind_t'(s_tuser);
            key_reg <= s_tdata;
            idx     <= '0;
            if (kind_t'(s_tuser) != KIND_INSERT && cnt == '0) begin
              res_status <= ST_EMPTY;
              res_value  <= '0;
              state      <= S_EMIT;
            end else if (kind_t'(s_tuser) == KIND_DUMP) begin
              state <= S_DUMP_RD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        // Walk up to the first entry not below the key
        S_SCAN: begin
          if (idx == cnt) begin
            pos   <= idx;
            match <= 1'b0;
            state <= S_DECIDE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if ($signed(rd_data) < $signed(key_reg)) begin
            idx   <= idx_inc;
            state <= S_SCAN;
          end else begin
            pos   <= idx;
            match <= (rd_data == key_reg);
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_value <= '0;
          case (op)
            KIND_INSERT: begin
              if (match) begin
                res_status <= ST_DUP;
                state      <= S_EMIT;
              end else if (cnt == CNT_W'(CAPACITY)) begin
                res_status <= ST_FULL;
                state      <= S_EMIT;
              end else begin
                idx   <= cnt;
                state <= S_INS_RD;
              end
            end
            KIND_DELETE: begin
              if (match) begin
                idx   <= pos;
                state <= S_DEL_RD;
              end else begin
                res_status <= ST_NOTFOUND;
                state      <= S_EMIT;
              end
            end
            KIND_SEARCH: begin
              if (match) begin
                res_status <= ST_OK;
                res_value  <= key_reg;
              end else begin
                res_status <= ST_NOTFOUND;
              end
              state <= S_EMIT;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        // Shift entries up to open the slot at pos
        S_INS_RD: begin
          state <= (idx == pos) ? S_INS_PUT : S_INS_WR;
        end
        S_INS_WR: begin
          idx   <= idx_dec;
          state <= S_INS_RD;
        end
        S_INS_PUT: begin
          cnt        <= cnt + CNT_W'(1);
          res_status <= ST_OK;
          state      <= S_EMIT;
        end
        // Shift entries down over the deleted slot
        S_DEL_RD: begin
          if (idx_inc == cnt) begin
            cnt        <= cnt - CNT_W'(1);
            res_status <= ST_OK;
            state      <= S_EMIT;
          end else begin
            state <= S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          idx   <= idx_inc;
          state <= S_DEL_RD;
        end
        // Emit stored keys in order
        S_DUMP_RD: begin
          state <= S_DUMP_OUT;
        end
        S_DUMP_OUT: begin
          if (out_free) begin
            m_tdata  <= {(OUT_DATA_W - VALUE_W - COUNT_W)'(0), COUNT_W'(cnt), rd_data};
            m_tuser  <= ST_OK;
            m_tlast  <= dump_last;
            idx      <= idx_inc;
            state    <= dump_last ? S_IDLE : S_DUMP_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tdata  <= {(OUT_DATA_W - VALUE_W - COUNT_W)'(0), COUNT_W'(cnt), res_value};
            m_tuser  <= res_status;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("key count above capacity");

  a_nonok_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[VALUE_W-1:0] == '0)
    else $error("non-ok result carries a value");

  a_nonok_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tlast)
    else $error("non-ok result not marked last");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready held after accepting an item");

endmodule
